>>> hdl/cass_pkg.sv
// shared types, codes and defaults of the crank angle spark scheduler
package cass_pkg;

  localparam int MAX_CYLINDERS_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;

  localparam int FIRE_W   = 16;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int CYL_W    = 5;
  localparam int LIMIT_W  = 15;
  localparam int HOLD_W   = 24;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_RESYNC = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_PROG   = 2'd3;

  localparam logic [1:0] REG_CYLINDERS = 2'd0;
  localparam logic [1:0] REG_IGN_EN    = 2'd1;
  localparam logic [1:0] REG_LIMIT     = 2'd2;
  localparam logic [1:0] REG_HOLD      = 2'd3;

  typedef struct packed {
    logic [CYL_W-1:0]   cylinders;
    logic               ign_en;
    logic [LIMIT_W-1:0] speed_limit;
    logic [HOLD_W-1:0]  hold_us;
  } cass_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_TIMER,
    ST_DONE
  } cass_state_t;

endpackage

>>> hdl/cass_if.sv
// valid/ready channel interfaces for items and results
interface cass_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [3:0]         cylinder_index;
  logic [15:0]        plug_angle;
  logic [15:0]        cycle_angle;
  logic signed [15:0] angular_velocity;
  logic signed [15:0] timing_advance;
  logic [15:0]        elapsed_us;

  modport source (output valid, kind, cylinder_index, plug_angle, cycle_angle,
                  angular_velocity, timing_advance, elapsed_us, input ready);
  modport sink (input valid, kind, cylinder_index, plug_angle, cycle_angle,
                angular_velocity, timing_advance, elapsed_us, output ready);
endinterface

interface cass_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fire_mask;
  logic        limiter_active;

  modport source (output valid, fire_mask, limiter_active, input ready);
  modport sink (input valid, fire_mask, limiter_active, output ready);
endinterface

>>> hdl/cass_ram.sv
// generic single write port ram with registered read
module cass_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/cass_cfg.sv
// apb register file holding the scheduler configuration
module cass_cfg
  import cass_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cass_cfg_t         cfg
);

  cass_cfg_t  cfg_r, cfg_nxt;
  logic [1:0] idx;
  logic       wr;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[CFG_AW-1:2];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_CYLINDERS: cfg_nxt.cylinders   = cfg_pwdata[CYL_W-1:0];
        REG_IGN_EN:    cfg_nxt.ign_en      = cfg_pwdata[0];
        REG_LIMIT:     cfg_nxt.speed_limit = cfg_pwdata[LIMIT_W-1:0];
        REG_HOLD:      cfg_nxt.hold_us     = cfg_pwdata[HOLD_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CYLINDERS: cfg_prdata = CFG_DW'(cfg_r.cylinders);
      REG_IGN_EN:    cfg_prdata = CFG_DW'(cfg_r.ign_en);
      REG_LIMIT:     cfg_prdata = CFG_DW'(cfg_r.speed_limit);
      REG_HOLD:      cfg_prdata = CFG_DW'(cfg_r.hold_us);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cylinders   <= CYL_W'(1);
      cfg_r.ign_en      <= 1'b0;
      cfg_r.speed_limit <= '0;
      cfg_r.hold_us     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/crank_angle_spark_scheduler_top.sv
// crank angle spark scheduler: sequencer, cylinder scan and rev limiter
//
// items arrive on in_if (valid/ready); each item gives exactly one result on
// out_if carrying the sticky fire bits and the limiter flag after the item.
// kinds: update tick, resync angle and clear, clear fire bits, program plug.
// settings come over an apb port (cfg_*) and are to be written only while
// the block idles; the block does not enforce this. an update tick with
// ignition enabled and the limiter idle scans the in-use cylinders one per
// cycle through the firing angle ram and one shared subtract/compare unit,
// between decode and the timer and output steps; other kinds skip the scan
// and timer steps, suppressed ticks only the scan. in_if.ready is high only
// in idle, so one item is at work at a time; a finished result sits in the
// output register and the next item is accepted meanwhile. if the receiver
// stalls, the result holds and a following item waits after its work until
// the output register frees. synchronous reset clears fire bits, plug
// enables, previous angle and hold timer and resets settings; the ram needs
// no clearing since a plug that was never programmed reads as angle zero.
module crank_angle_spark_scheduler_top
  import cass_pkg::*;
#(
  parameter int MAX_CYLINDERS = MAX_CYLINDERS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cass_in_if.sink           in_if,
  cass_out_if.source        out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW   = ANGLE_BITS;
  localparam int CW   = $clog2(MAX_CYLINDERS + 1);
  localparam int IW   = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1;
  localparam int CMPW = (CW > CYL_W) ? CW : CYL_W;
  localparam int MAGW = 17;

  cass_cfg_t   cfg;
  cass_state_t state_r, state_nxt;

  // item fields
  logic [1:0]      kind_r;
  logic [3:0]      cidx_r;
  logic [AW-1:0]   plug_r, cur_r, adv_r;
  logic            fwd_r;
  logic [MAGW-1:0] mag_r;
  logic [15:0]     dt_r;

  // block state
  logic [AW-1:0]            prev_r, prev_nxt;
  logic [HOLD_W-1:0]        hold_r, hold_nxt;
  logic [MAX_CYLINDERS-1:0] en_r, en_nxt;
  logic [MAX_CYLINDERS-1:0] ev_r, ev_nxt;

  // scan control
  logic [AW-1:0] lo_r, lo_nxt, span_r, span_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [FIRE_W-1:0] out_mask_r, out_mask_nxt;
  logic              out_lim_r, out_lim_nxt;

  logic                     accept;
  logic [CMPW-1:0]          cyl_ext;
  logic [CW-1:0]            n_eff;
  logic [MAX_CYLINDERS-1:0] use_mask;
  logic                     prog_ok;
  logic                     scan_ok;
  logic                     issue;
  logic                     ram_we;
  logic [AW-1:0]            ram_rdata;
  logic [AW-1:0]            tbl, ang, arc_off;
  logic                     hit;
  logic [AW-1:0]            lo_c, hi_c;
  logic [MAGW-1:0]          vel_ext;

  cass_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);

  // effective cylinder count, clamped to the table depth
  assign cyl_ext = CMPW'(cfg.cylinders);
  assign n_eff   = (cyl_ext > CMPW'(MAX_CYLINDERS)) ? CW'(MAX_CYLINDERS) : CW'(cyl_ext);

  always_comb begin
    for (int i = 0; i < MAX_CYLINDERS; i++) begin
      use_mask[i] = (CW'(i) < n_eff);
    end
  end

  assign prog_ok = (CMPW'(cidx_r) < CMPW'(n_eff));
  assign scan_ok = cfg.ign_en && (hold_r == '0);
  assign issue   = (state_r == ST_SCAN) && (iss_r < n_eff);
  assign ram_we  = (state_r == ST_DECODE) && (kind_r == KIND_PROG) && prog_ok;

  cass_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_CYLINDERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(cidx_r)),
    .wdata (plug_r),
    .raddr (iss_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // shared angle unit: advance applied, then modular arc test
  assign tbl     = en_r[chk_idx_r] ? ram_rdata : '0;
  assign ang     = tbl - adv_r;
  assign arc_off = ang - lo_r;
  assign hit     = (arc_off < span_r);

  assign lo_c    = fwd_r ? prev_r : cur_r;
  assign hi_c    = fwd_r ? cur_r : prev_r;
  assign vel_ext = {in_if.angular_velocity[15], in_if.angular_velocity};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (kind_r == KIND_UPDATE) state_nxt = scan_ok ? ST_SCAN : ST_TIMER;
        else state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (!issue && !chk_v_r) state_nxt = ST_TIMER;
      end
      ST_TIMER: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    prev_nxt      = prev_r;
    hold_nxt      = hold_r;
    en_nxt        = en_r;
    ev_nxt        = ev_r;
    lo_nxt        = lo_r;
    span_nxt      = span_r;
    iss_nxt       = iss_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_mask_nxt  = out_mask_r;
    out_lim_nxt   = out_lim_r;
    unique case (state_r)
      ST_IDLE: ;
      ST_DECODE: begin
        unique case (kind_r)
          KIND_UPDATE: begin
            lo_nxt   = lo_c;
            span_nxt = hi_c - lo_c;
            iss_nxt  = '0;
          end
          KIND_RESYNC: begin
            prev_nxt = cur_r;
            ev_nxt   = ev_r & ~use_mask;
          end
          KIND_CLEAR: ev_nxt = ev_r & ~use_mask;
          KIND_PROG: begin
            if (prog_ok) en_nxt = en_r | (MAX_CYLINDERS'(1) << cidx_r);
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (issue) begin
          iss_nxt     = iss_r + CW'(1);
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = iss_r[IW-1:0];
        end
        // disabled plug in the arc clears its bit
        if (chk_v_r && hit) ev_nxt[chk_idx_r] = en_r[chk_idx_r];
      end
      ST_TIMER: begin
        hold_nxt = (hold_r > HOLD_W'(dt_r)) ? (hold_r - HOLD_W'(dt_r)) : '0;
        if (mag_r > MAGW'(cfg.speed_limit)) hold_nxt = cfg.hold_us;
        prev_nxt = cur_r;
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = FIRE_W'(ev_r);
          out_lim_nxt   = (hold_r != '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      hold_r      <= '0;
      en_r        <= '0;
      ev_r        <= '0;
      iss_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      hold_r      <= hold_nxt;
      en_r        <= en_nxt;
      ev_r        <= ev_nxt;
      iss_r       <= iss_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    span_r     <= span_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_mask_r <= out_mask_nxt;
    out_lim_r  <= out_lim_nxt;
    if (accept) begin
      kind_r <= in_if.kind;
      cidx_r <= in_if.cylinder_index;
      plug_r <= AW'(in_if.plug_angle);
      cur_r  <= AW'(in_if.cycle_angle);
      adv_r  <= AW'(in_if.timing_advance);
      fwd_r  <= in_if.angular_velocity[15];
      mag_r  <= in_if.angular_velocity[15] ? (MAGW'(0) - vel_ext) : vel_ext;
      dt_r   <= in_if.elapsed_us;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.fire_mask      = out_mask_r;
  assign out_if.limiter_active = out_lim_r;

endmodule

>>> hdl/cass_checker.sv
// port-level checks of the scheduler handshakes, bound to the top level
module cass_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_fire_mask,
  input logic        out_limiter_active
);

  // an accepted item keeps the block busy through its decode and output steps
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input accepted again too soon after an item");

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("result pending or input closed after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_fire_mask) && $stable(out_limiter_active)))
    else $error("stalled result changed");

endmodule

bind crank_angle_spark_scheduler_top cass_checker u_cass_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_fire_mask      (out_if.fire_mask),
  .out_limiter_active (out_if.limiter_active)
);
